// File: src/awst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awst_pkg
// Shared types, codes and helpers of the adaptive width string table.
// ----------------------------------------------------------------------------
package awst_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int SLOT_BYTES_DEF  = 64;
  localparam int PEND_MAX        = 64;

  // operation kinds
  localparam logic [2:0] K_SET    = 3'd0;
  localparam logic [2:0] K_INSERT = 3'd1;
  localparam logic [2:0] K_DELETE = 3'd2;
  localparam logic [2:0] K_FIND   = 3'd3;
  localparam logic [2:0] K_READ   = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_INDEX = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_WR_RD, S_WR_WR, S_CP_RD, S_CP_WR,
    S_FD_RD, S_FD_CHK, S_RD_RD, S_RD_CHK, S_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] index;
    logic [6:0] range_end;
    logic       search_to_end;
    logic [7:0] value_byte;
    logic       byte_present;
    logic       last_item;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] found_position;
    logic [7:0] read_byte;
    logic       last_result;
    logic [6:0] column_width;
    logic [6:0] entry_count;
  } res_t;

  // pending byte buffer port
  typedef struct packed {
    logic       we;
    logic [5:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [5:0] raddr;
  } pend_port_t;

  // column width needed by a string of the given length
  function automatic logic [7:0] width_for(input logic [6:0] len);
    logic [7:0] w;
    w = {1'b0, len};
    w = w | (w >> 1);
    w = w | (w >> 2);
    w = w | (w >> 4);
    if (len == 7'd0) begin
      return 8'd0;
    end else if (len < 7'd3) begin
      return 8'd4;
    end
    return w + 8'd1;
  endfunction

endpackage

// File: src/awst_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awst_req_if
// Request channel: valid, ready and one input item.
// ----------------------------------------------------------------------------
interface awst_req_if;
  logic           valid;
  logic           ready;
  awst_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/awst_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awst_res_if
// Result channel: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface awst_res_if;
  logic           valid;
  logic           ready;
  awst_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/awst_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awst_store
// Entry byte memory (row by column) and pending byte buffer, registered reads.
// ----------------------------------------------------------------------------
module awst_store #(
  parameter int MAX_ENTRIES = awst_pkg::MAX_ENTRIES_DEF,
  parameter int SLOT_BYTES  = awst_pkg::SLOT_BYTES_DEF,
  localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int AW = $clog2(MAX_ENTRIES * SLOT_BYTES)
) (
  input  logic                 clk,
  input  awst_pkg::pend_port_t pend,
  output logic [7:0]           pdata,
  input  logic                 we,
  input  logic [RW-1:0]        wrow,
  input  logic [5:0]           wcol,
  input  logic [7:0]           wdata,
  input  logic                 re,
  input  logic [RW-1:0]        rrow,
  input  logic [5:0]           rcol,
  output logic [7:0]           rdata
);

  logic [7:0] mem [MAX_ENTRIES*SLOT_BYTES];
  logic [7:0] pbuf [awst_pkg::PEND_MAX];
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  // flatten row and column into a byte address
  assign waddr = AW'(wrow) * AW'(SLOT_BYTES) + AW'(wcol);
  assign raddr = AW'(rrow) * AW'(SLOT_BYTES) + AW'(rcol);

  // entry memory, read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // pending bytes of the request being gathered
  always_ff @(posedge clk) begin
    if (pend.we) begin
      pbuf[pend.waddr] <= pend.wdata;
    end
    if (pend.re) begin
      pdata <= pbuf[pend.raddr];
    end
  end

endmodule

// File: src/adaptive_width_string_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_width_string_table
// Ordered table of zero padded strings sharing one growing column width.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | kind, index, range_end, search_to_end, value_byte,
//          |     | byte_present, last_item
//  res     | out | status, found_position, read_byte, last_result,
//          |     | column_width, entry_count
//
// A request without last_item only gathers its byte. On the last item, checks
// answer straight from S_IDLE; set writes a row through S_WR_RD and S_WR_WR
// per byte, insert and delete move each shifted row through S_CP_RD and
// S_CP_WR per byte, find compares through S_FD_RD and S_FD_CHK per byte, and
// read streams through S_RD_RD and S_RD_CHK per byte; each ends in S_FINISH.
// Reset clears the counters and state; memory contents need no clearing.
// A stalled result holds the sequencer until it is taken.
// ----------------------------------------------------------------------------
module adaptive_width_string_table #(
  parameter int MAX_ENTRIES = awst_pkg::MAX_ENTRIES_DEF,
  parameter int SLOT_BYTES  = awst_pkg::SLOT_BYTES_DEF
) (
  input logic      clk,
  input logic      rst,
  awst_req_if.sink req,
  awst_res_if.source res
);

  localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = (CW > 7) ? CW : 7;
  localparam logic [5:0] LAST_COL = 6'(SLOT_BYTES - 1);

  awst_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [6:0]    width, width_next;
  logic [6:0]    plen, plen_next;
  logic [6:0]    len, len_next;
  logic [XW-1:0] idx_r, idx_r_next;
  logic [XW-1:0] dst, dst_next;
  logic [XW-1:0] src, src_next;
  logic [XW-1:0] lim, lim_next;
  logic [5:0]    col, col_next;
  logic          up, up_next;
  logic [2:0]    st, st_next;
  logic [5:0]    pos, pos_next;
  logic          ovalid, ovalid_next;
  awst_pkg::res_t odata, odata_next;

  awst_pkg::pend_port_t pend;
  logic [7:0]    pdata, rdata, wdata;
  logic          we, re;
  logic [XW-1:0] wrow, rrow;

  logic          take, can_emit, put_byte, len_ok, hit;
  logic [6:0]    len_now;
  logic [7:0]    need;
  logic          too_long;
  logic [XW-1:0] idx_x, cnt_x, end_x;

  awst_store #(.MAX_ENTRIES(MAX_ENTRIES), .SLOT_BYTES(SLOT_BYTES)) u_store (
    .clk  (clk),
    .pend (pend),
    .pdata(pdata),
    .we   (we),
    .wrow (wrow[RW-1:0]),
    .wcol (col),
    .wdata(wdata),
    .re   (re),
    .rrow (rrow[RW-1:0]),
    .rcol (col),
    .rdata(rdata)
  );

  assign req.ready = (state == awst_pkg::S_IDLE) && !ovalid;
  assign take      = req.valid && req.ready;
  assign can_emit  = !ovalid || res.ready;
  assign res.valid = ovalid;
  assign res.data  = odata;

  // decode of the request being taken
  assign put_byte = req.data.byte_present && (plen < 7'(awst_pkg::PEND_MAX));
  assign len_now  = plen + {6'd0, put_byte};
  assign need     = awst_pkg::width_for(len_now);
  assign too_long = need > 8'(SLOT_BYTES);
  assign idx_x    = XW'(req.data.index);
  assign cnt_x    = XW'(count);
  assign end_x    = req.data.search_to_end ? cnt_x : XW'(req.data.range_end);
  assign len_ok   = {1'b0, col} < len;
  assign hit      = len_ok ? (rdata == pdata) : (rdata == 8'd0);

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= awst_pkg::S_IDLE;
      count  <= '0;
      width  <= '0;
      plen   <= '0;
      ovalid <= 1'b0;
      col    <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      width  <= width_next;
      plen   <= plen_next;
      ovalid <= ovalid_next;
      col    <= col_next;
    end
    len   <= len_next;
    idx_r <= idx_r_next;
    dst   <= dst_next;
    src   <= src_next;
    lim   <= lim_next;
    up    <= up_next;
    st    <= st_next;
    pos   <= pos_next;
    odata <= odata_next;
  end

  // sequencer
  always_comb begin
    state_next  = state;
    count_next  = count;
    width_next  = width;
    plen_next   = plen;
    len_next    = len;
    idx_r_next  = idx_r;
    dst_next    = dst;
    src_next    = src;
    lim_next    = lim;
    col_next    = col;
    up_next     = up;
    st_next     = st;
    pos_next    = pos;
    ovalid_next = ovalid && !res.ready;
    odata_next  = odata;
    pend.we     = 1'b0;
    pend.waddr  = plen[5:0];
    pend.wdata  = req.data.value_byte;
    pend.re     = 1'b0;
    pend.raddr  = col;
    we          = 1'b0;
    re          = 1'b0;
    wrow        = dst;
    rrow        = src;
    wdata       = len_ok ? pdata : 8'd0;

    unique case (state)
      awst_pkg::S_IDLE: begin
        if (take) begin
          // gather the byte, run the operation on the last item
          pend.we   = put_byte;
          plen_next = len_now;
          if (req.data.last_item) begin
            plen_next  = '0;
            len_next   = len_now;
            idx_r_next = idx_x;
            col_next   = '0;
            st_next    = awst_pkg::ST_OK;
            pos_next   = '0;
            odata_next = '{status: awst_pkg::ST_OK, found_position: 6'd0,
                           read_byte: 8'd0, last_result: 1'b1,
                           column_width: width, entry_count: 7'(count)};
            ovalid_next = 1'b1;
            case (req.data.kind)
              awst_pkg::K_SET: begin
                if (idx_x >= cnt_x) begin
                  odata_next.status = awst_pkg::ST_BAD_INDEX;
                end else if (too_long) begin
                  odata_next.status = awst_pkg::ST_TOO_LONG;
                end else begin
                  ovalid_next = ovalid && !res.ready;
                  if (need > {1'b0, width}) width_next = need[6:0];
                  dst_next   = idx_x;
                  state_next = awst_pkg::S_WR_RD;
                end
              end
              awst_pkg::K_INSERT: begin
                if (idx_x > cnt_x) begin
                  odata_next.status = awst_pkg::ST_BAD_INDEX;
                end else if (cnt_x >= XW'(MAX_ENTRIES)) begin
                  odata_next.status = awst_pkg::ST_FULL;
                end else if (too_long) begin
                  odata_next.status = awst_pkg::ST_TOO_LONG;
                end else begin
                  ovalid_next = ovalid && !res.ready;
                  if (need > {1'b0, width}) width_next = need[6:0];
                  count_next = count + CW'(1);
                  up_next    = 1'b1;
                  if (cnt_x == idx_x) begin
                    dst_next   = idx_x;
                    state_next = awst_pkg::S_WR_RD;
                  end else begin
                    dst_next   = cnt_x;
                    src_next   = cnt_x - XW'(1);
                    state_next = awst_pkg::S_CP_RD;
                  end
                end
              end
              awst_pkg::K_DELETE: begin
                if (idx_x >= cnt_x) begin
                  odata_next.status = awst_pkg::ST_BAD_INDEX;
                end else begin
                  count_next = count - CW'(1);
                  odata_next.entry_count = 7'(count - CW'(1));
                  if (idx_x + XW'(1) != cnt_x) begin
                    ovalid_next = ovalid && !res.ready;
                    up_next    = 1'b0;
                    dst_next   = idx_x;
                    src_next   = idx_x + XW'(1);
                    lim_next   = cnt_x;
                    state_next = awst_pkg::S_CP_RD;
                  end
                end
              end
              awst_pkg::K_FIND: begin
                if (idx_x == end_x) begin
                  odata_next.status = awst_pkg::ST_NOT_FOUND;
                end else if (idx_x > end_x || end_x > cnt_x) begin
                  odata_next.status = awst_pkg::ST_BAD_INDEX;
                end else if (too_long) begin
                  odata_next.status = awst_pkg::ST_TOO_LONG;
                end else if (len_now >= width) begin
                  odata_next.status = awst_pkg::ST_NOT_FOUND;
                end else begin
                  ovalid_next = ovalid && !res.ready;
                  src_next   = idx_x;
                  lim_next   = end_x;
                  state_next = awst_pkg::S_FD_RD;
                end
              end
              awst_pkg::K_READ: begin
                if (idx_x >= cnt_x) begin
                  odata_next.status = awst_pkg::ST_BAD_INDEX;
                end else begin
                  ovalid_next = ovalid && !res.ready;
                  dst_next   = idx_x;
                  state_next = awst_pkg::S_RD_RD;
                end
              end
              default: begin
                // unknown kind: plain ok result
              end
            endcase
          end
        end
      end

      // write the pending string, zero padded, into row dst
      awst_pkg::S_WR_RD: begin
        pend.re    = 1'b1;
        state_next = awst_pkg::S_WR_WR;
      end
      awst_pkg::S_WR_WR: begin
        we = 1'b1;
        if (col == LAST_COL) begin
          col_next   = '0;
          state_next = awst_pkg::S_FINISH;
        end else begin
          col_next   = col + 6'd1;
          state_next = awst_pkg::S_WR_RD;
        end
      end

      // move row src into row dst, one byte a pass
      awst_pkg::S_CP_RD: begin
        re         = 1'b1;
        state_next = awst_pkg::S_CP_WR;
      end
      awst_pkg::S_CP_WR: begin
        we    = 1'b1;
        wdata = rdata;
        state_next = awst_pkg::S_CP_RD;
        col_next   = col + 6'd1;
        if (col == LAST_COL) begin
          col_next = '0;
          dst_next = src;
          if (up) begin
            src_next = src - XW'(1);
            if (src == idx_r) state_next = awst_pkg::S_WR_RD;
          end else begin
            src_next = src + XW'(1);
            if (src + XW'(1) == lim) state_next = awst_pkg::S_FINISH;
          end
        end
      end

      // compare row src with the pending string and its terminator
      awst_pkg::S_FD_RD: begin
        re         = 1'b1;
        pend.re    = 1'b1;
        state_next = awst_pkg::S_FD_CHK;
      end
      awst_pkg::S_FD_CHK: begin
        state_next = awst_pkg::S_FD_RD;
        if (hit && !len_ok) begin
          st_next    = awst_pkg::ST_OK;
          pos_next   = src[5:0];
          col_next   = '0;
          state_next = awst_pkg::S_FINISH;
        end else if (hit) begin
          col_next = col + 6'd1;
        end else begin
          col_next = '0;
          src_next = src + XW'(1);
          if (src + XW'(1) == lim) begin
            st_next    = awst_pkg::ST_NOT_FOUND;
            state_next = awst_pkg::S_FINISH;
          end
        end
      end

      // stream the bytes of row dst until a zero, the width or the last column
      awst_pkg::S_RD_RD: begin
        rrow = dst;
        if ({1'b0, col} < width && {1'b0, col} < 7'(SLOT_BYTES - 1)) begin
          re         = 1'b1;
          state_next = awst_pkg::S_RD_CHK;
        end else begin
          col_next   = '0;
          state_next = awst_pkg::S_FINISH;
        end
      end
      awst_pkg::S_RD_CHK: begin
        if (rdata == 8'd0) begin
          col_next   = '0;
          state_next = awst_pkg::S_FINISH;
        end else if (can_emit) begin
          ovalid_next = 1'b1;
          odata_next  = '{status: awst_pkg::ST_OK, found_position: 6'd0,
                          read_byte: rdata, last_result: 1'b0,
                          column_width: width, entry_count: 7'(count)};
          col_next    = col + 6'd1;
          state_next  = awst_pkg::S_RD_RD;
        end
      end

      // hand out the closing result
      awst_pkg::S_FINISH: begin
        if (can_emit) begin
          ovalid_next = 1'b1;
          odata_next  = '{status: st, found_position: pos, read_byte: 8'd0,
                          last_result: 1'b1, column_width: width,
                          entry_count: 7'(count)};
          state_next  = awst_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = awst_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: tb/adaptive_width_string_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_width_string_table_test
// Self-checking bench for the adaptive width string table. Requests are
// built as whole operations (string bytes, then the item that runs the
// operation) and queued by a stimulus process. A clocked driver offers
// them with random gaps. A clocked monitor takes results with random
// stalls and compares each one, field by field, with the oldest expected
// result. Expected results come from a table model that is updated on
// every accepted request.
// ----------------------------------------------------------------------------
module adaptive_width_string_table_test;
  import awst_pkg::*;

  localparam int ROWS      = 64;
  localparam int COLS      = 64;
  localparam int IDLE_MAX  = 40000;
  localparam int N_ITEMS   = 380;

  typedef struct {
    req_t r;
    bit   drain;
  } pend_item_t;

  typedef struct {
    logic [7:0] b [64];
    int         len;
  } word_t;

  logic clk;
  logic rst;

  awst_req_if req ();
  awst_res_if res ();

  adaptive_width_string_table dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .res (res.source)
  );

  // table model state
  logic [7:0] tbl_rows [ROWS][COLS];
  int         tbl_count;
  int         tbl_width;
  logic [7:0] gather_bytes [COLS];
  int         gather_len;

  res_t       result_q [$];
  pend_item_t request_q [$];
  word_t      word_pool [$];
  logic [7:0] str_q [$];

  int  errors;
  int  req_taken;
  int  res_taken;
  int  items_made;
  int  gen_count;
  int  send_gap;
  int  take_gap;
  int  idle_cycles;
  bit  hold_res;
  bit  seen_full;
  bit  seen_wide;
  bit  seen_long;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int width_needed(int len);
    int w;
    w = 1;
    if (len == 0) begin
      return 0;
    end else if (len < 3) begin
      return 4;
    end
    while (w <= len) begin
      w = w * 2;
    end
    return w;
  endfunction

  function automatic void push_result(logic [2:0] st, int pos, logic [7:0] b, bit last);
    res_t e;
    e.status         = st;
    e.found_position = pos[5:0];
    e.read_byte      = b;
    e.last_result    = last;
    e.column_width   = tbl_width[6:0];
    e.entry_count    = tbl_count[6:0];
    result_q.push_back(e);
  endfunction

  function automatic void load_row(int idx, int len);
    for (int j = 0; j < COLS; j++) begin
      tbl_rows[idx][j] = (j < len) ? gather_bytes[j] : 8'd0;
    end
  endfunction

  // update the table model with one accepted request
  function automatic void model_request(req_t r);
    int  len;
    int  need;
    int  stop;
    int  idx;
    int  n;
    bit  hit;
    bit  too_long;
    idx = r.index;
    if (r.byte_present && gather_len < COLS) begin
      gather_bytes[gather_len] = r.value_byte;
      gather_len++;
    end
    if (!r.last_item) begin
      return;
    end
    len = gather_len;
    gather_len = 0;
    need = width_needed(len);
    too_long = need > COLS;
    case (r.kind)
      K_SET: begin
        if (idx >= tbl_count) begin
          push_result(ST_BAD_INDEX, 0, 8'd0, 1'b1);
        end else if (too_long) begin
          push_result(ST_TOO_LONG, 0, 8'd0, 1'b1);
        end else begin
          if (need > tbl_width) tbl_width = need;
          load_row(idx, len);
          push_result(ST_OK, 0, 8'd0, 1'b1);
        end
      end
      K_INSERT: begin
        if (idx > tbl_count) begin
          push_result(ST_BAD_INDEX, 0, 8'd0, 1'b1);
        end else if (tbl_count >= ROWS) begin
          seen_full = 1'b1;
          push_result(ST_FULL, 0, 8'd0, 1'b1);
        end else if (too_long) begin
          push_result(ST_TOO_LONG, 0, 8'd0, 1'b1);
        end else begin
          if (need > tbl_width) tbl_width = need;
          for (int k = tbl_count; k > idx; k--) begin
            for (int j = 0; j < COLS; j++) tbl_rows[k][j] = tbl_rows[k-1][j];
          end
          load_row(idx, len);
          tbl_count++;
          push_result(ST_OK, 0, 8'd0, 1'b1);
        end
      end
      K_DELETE: begin
        if (idx >= tbl_count) begin
          push_result(ST_BAD_INDEX, 0, 8'd0, 1'b1);
        end else begin
          for (int k = idx; k + 1 < tbl_count; k++) begin
            for (int j = 0; j < COLS; j++) tbl_rows[k][j] = tbl_rows[k+1][j];
          end
          tbl_count--;
          push_result(ST_OK, 0, 8'd0, 1'b1);
        end
      end
      K_FIND: begin
        stop = r.search_to_end ? tbl_count : int'(r.range_end);
        if (idx == stop) begin
          push_result(ST_NOT_FOUND, 0, 8'd0, 1'b1);
        end else if (idx > stop || stop > tbl_count) begin
          push_result(ST_BAD_INDEX, 0, 8'd0, 1'b1);
        end else if (too_long) begin
          push_result(ST_TOO_LONG, 0, 8'd0, 1'b1);
        end else if (len >= tbl_width) begin
          push_result(ST_NOT_FOUND, 0, 8'd0, 1'b1);
        end else begin
          n = -1;
          for (int k = idx; k < stop && n < 0; k++) begin
            hit = tbl_rows[k][len] == 8'd0;
            for (int j = 0; j < len; j++) begin
              if (tbl_rows[k][j] != gather_bytes[j]) hit = 1'b0;
            end
            if (hit) n = k;
          end
          if (n >= 0) begin
            push_result(ST_OK, n, 8'd0, 1'b1);
          end else begin
            push_result(ST_NOT_FOUND, 0, 8'd0, 1'b1);
          end
        end
      end
      K_READ: begin
        if (idx >= tbl_count) begin
          push_result(ST_BAD_INDEX, 0, 8'd0, 1'b1);
        end else begin
          n = 0;
          while (n < tbl_width && n < COLS - 1 && tbl_rows[idx][n] != 8'd0) begin
            push_result(ST_OK, 0, tbl_rows[idx][n], 1'b0);
            n++;
          end
          push_result(ST_OK, 0, 8'd0, 1'b1);
        end
      end
      default: begin
        push_result(ST_OK, 0, 8'd0, 1'b1);
      end
    endcase
    if (tbl_width == COLS) seen_wide = 1'b1;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // queue one operation: the bytes of str_q, then the item that runs it
  task automatic queue_op(logic [2:0] kind, int idx, int rend, bit to_end, bit drain);
    pend_item_t it;
    int         n;
    bit         carry;
    n = str_q.size();
    carry = (n > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < n - (carry ? 1 : 0); i++) begin
      // drop in an ignored byte now and then
      if ($urandom_range(0, 9) == 0) begin
        it.r = '0;
        it.r.kind = 3'($urandom_range(0, 7));
        it.r.value_byte = 8'($urandom_range(0, 255));
        it.r.index = 7'($urandom_range(0, 127));
        it.drain = 1'b0;
        request_q.push_back(it);
        items_made++;
      end
      it.r = '0;
      it.r.kind = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : kind;
      it.r.index = 7'($urandom_range(0, 127));
      it.r.range_end = 7'($urandom_range(0, 127));
      it.r.value_byte = str_q[i];
      it.r.byte_present = 1'b1;
      it.drain = drain && (i == 0);
      request_q.push_back(it);
      items_made++;
    end
    it.r = '0;
    it.r.kind = kind;
    it.r.index = idx[6:0];
    it.r.range_end = rend[6:0];
    it.r.search_to_end = to_end;
    it.r.value_byte = carry ? str_q[n-1] : 8'($urandom_range(0, 255));
    it.r.byte_present = carry;
    it.r.last_item = 1'b1;
    it.drain = drain && (n - (carry ? 1 : 0) == 0);
    request_q.push_back(it);
    items_made++;
    if (str_q.size() >= 64) seen_long = 1'b1;
    // track the entry count for choosing useful indexes
    case (kind)
      K_INSERT: if (idx <= gen_count && gen_count < ROWS && n < 64) gen_count++;
      K_DELETE: if (idx < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  task automatic make_string(int len);
    word_t w;
    str_q.delete();
    for (int i = 0; i < len; i++) str_q.push_back(8'($urandom_range(1, 255)));
    if (len > 0 && len < 64) begin
      w.len = len;
      for (int i = 0; i < len; i++) w.b[i] = str_q[i];
      word_pool.push_back(w);
      if (word_pool.size() > 24) void'(word_pool.pop_front());
    end
  endtask

  task automatic make_text(string s);
    str_q.delete();
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
  endtask

  function automatic int rand_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8) return 0;
    if (p < 85) return $urandom_range(1, 6);
    if (p < 95) return $urandom_range(7, 31);
    if (p < 98) return $urandom_range(32, 63);
    return $urandom_range(64, 70);
  endfunction

  // pick an index near the end of the table to keep shifts short
  function automatic int near_end(int cnt, bit allow_bad);
    int p;
    p = $urandom_range(0, 99);
    if (allow_bad && p < 8) return $urandom_range(cnt, 64);
    if (p < 70 || cnt == 0) return cnt - $urandom_range(0, (cnt < 3) ? cnt : 3);
    return $urandom_range(0, cnt);
  endfunction

  // build the request stream
  initial begin
    int  kind_pick;
    int  idx;
    int  lo;
    int  hi;
    int  ops;
    bit  drain;
    word_t w;
    for (int i = 0; i < ROWS; i++) begin
      for (int j = 0; j < COLS; j++) tbl_rows[i][j] = 8'd0;
    end
    for (int j = 0; j < COLS; j++) gather_bytes[j] = 8'd0;
    tbl_count = 0;
    tbl_width = 0;
    gather_len = 0;
    errors = 0;
    req_taken = 0;
    res_taken = 0;
    items_made = 0;
    gen_count = 0;
    seen_full = 0;
    seen_wide = 0;
    seen_long = 0;

    // directed: basic operations, bad indexes, find ranges, width growth
    make_text("");   queue_op(K_READ, 0, 0, 1'b0, 1'b0);
    make_text("A");  queue_op(K_INSERT, 0, 0, 1'b0, 1'b0);
    make_text("");   queue_op(K_READ, 0, 0, 1'b0, 1'b0);
    make_text("xyz"); queue_op(K_INSERT, 1, 0, 1'b0, 1'b0);
    make_text("");   queue_op(K_INSERT, 0, 0, 1'b0, 1'b0);
    make_text("Q");  queue_op(K_INSERT, 64, 0, 1'b0, 1'b0);
    make_text("A");  queue_op(K_FIND, 0, 0, 1'b1, 1'b0);
    make_text("A");  queue_op(K_FIND, 2, 2, 1'b0, 1'b0);
    make_text("A");  queue_op(K_FIND, 3, 1, 1'b0, 1'b0);
    make_text("A");  queue_op(K_FIND, 0, 64, 1'b0, 1'b0);
    make_text("abcd"); queue_op(K_FIND, 0, 0, 1'b1, 1'b0);
    make_text("");   queue_op(K_READ, 2, 0, 1'b0, 1'b0);
    make_text("");   queue_op(K_READ, 64, 0, 1'b0, 1'b0);
    make_text("");   queue_op(3'd7, 0, 0, 1'b0, 1'b0);
    // a zero byte marked present cuts the read short
    str_q.delete();
    str_q.push_back(8'hff); str_q.push_back(8'h00); str_q.push_back(8'h01);
    queue_op(K_SET, 1, 0, 1'b0, 1'b0);
    make_text("");   queue_op(K_READ, 1, 0, 1'b0, 1'b0);
    make_text("");   queue_op(K_DELETE, 5, 0, 1'b0, 1'b0);
    make_text("");   queue_op(K_DELETE, 0, 0, 1'b0, 1'b0);
    make_text("");   queue_op(3'd5, 0, 0, 1'b0, 1'b0);

    // random operations; fill the table in the first part, then mix
    ops = 0;
    while (items_made < N_ITEMS) begin
      drain = (ops == 0) || (ops == 60);
      kind_pick = $urandom_range(0, 99);
      if (items_made < N_ITEMS / 2) kind_pick = kind_pick / 2;
      if (kind_pick < 40) begin
        make_string(rand_len());
        queue_op(K_INSERT, near_end(gen_count, 1'b1), 0, 1'b0, drain);
      end else if (kind_pick < 55) begin
        make_string(rand_len());
        idx = (gen_count == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(0, 64)
                                                            : $urandom_range(0, gen_count - 1);
        queue_op(K_SET, idx, 0, 1'b0, drain);
      end else if (kind_pick < 66) begin
        str_q.delete();
        idx = (gen_count == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(0, 64)
                                                            : near_end(gen_count - 1, 1'b0);
        queue_op(K_DELETE, idx, 0, 1'b0, drain);
      end else if (kind_pick < 82) begin
        if (word_pool.size() > 0 && $urandom_range(0, 2) != 0) begin
          w = word_pool[$urandom_range(0, word_pool.size() - 1)];
          str_q.delete();
          for (int i = 0; i < w.len; i++) str_q.push_back(w.b[i]);
        end else begin
          make_string(rand_len());
        end
        lo = $urandom_range(0, gen_count);
        hi = $urandom_range(lo, gen_count);
        if ($urandom_range(0, 9) == 0) begin
          lo = $urandom_range(0, 64);
          hi = $urandom_range(0, 64);
        end
        queue_op(K_FIND, lo, hi, 1'($urandom_range(0, 1)), drain);
      end else if (kind_pick < 96) begin
        str_q.delete();
        idx = (gen_count == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(0, 64)
                                                            : $urandom_range(0, gen_count - 1);
        queue_op(K_READ, idx, 0, 1'b0, drain);
      end else begin
        make_string($urandom_range(0, 3));
        queue_op(3'($urandom_range(5, 7)), $urandom_range(0, 64), 0, 1'b0, drain);
      end
      ops++;
    end

    wait (request_q.size() == 0 && result_q.size() == 0);
    repeat (300) @(posedge clk);
    $display("ran %0d requests, checked %0d results, %0d entries left, width %0d",
             req_taken, res_taken, tbl_count, tbl_width);
    $display("table full seen: %0d, width 64 seen: %0d, over-long string seen: %0d",
             seen_full, seen_wide, seen_long);
    if (errors == 0 && result_q.size() == 0) begin
      $display("** adaptive_width_string_table: PASSED **");
    end else begin
      $display("** adaptive_width_string_table: FAILED **");
    end
    $finish;
  end

  // reset
  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // long result hold-off while requests keep coming
  initial begin
    hold_res = 1'b0;
    wait (req_taken >= 150);
    @(posedge clk);
    hold_res <= 1'b1;
    repeat (500) @(posedge clk);
    hold_res <= 1'b0;
  end

  // driver: offer queued requests with random gaps
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.data  <= '0;
      send_gap  = 0;
    end else begin
      if (req.valid && req.ready) begin
        model_request(req.data);
        void'(request_q.pop_front());
        req_taken++;
        send_gap = pick_gap();
      end else if (!req.valid && send_gap > 0) begin
        send_gap--;
      end
      if (req.valid && !req.ready) begin
        // hold the offered request
      end else if (send_gap == 0 && request_q.size() > 0 &&
                   !(request_q[0].drain && result_q.size() > 0)) begin
        req.valid <= 1'b1;
        req.data  <= request_q[0].r;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch on result %0d: %s got %0d, expected %0d", res_taken, what, got, want);
  endtask

  // monitor: take results with random stalls and check them
  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      res.ready <= 1'b0;
      take_gap  = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (result_q.size() == 0) begin
          report("unexpected result, status", res.data.status, 0);
        end else begin
          e = result_q.pop_front();
          if (res.data.status != e.status) report("status", res.data.status, e.status);
          if (res.data.found_position != e.found_position)
            report("found_position", res.data.found_position, e.found_position);
          if (res.data.read_byte != e.read_byte)
            report("read_byte", res.data.read_byte, e.read_byte);
          if (res.data.last_result != e.last_result)
            report("last_result", res.data.last_result, e.last_result);
          if (res.data.column_width != e.column_width)
            report("column_width", res.data.column_width, e.column_width);
          if (res.data.entry_count != e.entry_count)
            report("entry_count", res.data.entry_count, e.entry_count);
        end
        res_taken++;
        take_gap = pick_gap();
      end else if (take_gap > 0) begin
        take_gap--;
      end
      res.ready <= !hold_res && take_gap == 0;
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("timeout: no transfer for %0d cycles", IDLE_MAX);
      $display("** adaptive_width_string_table: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
